// ===== rtl/core/atw_pkg.sv =====
// ----------------------------------------------------------------------------
// atw_pkg: shared types and constants of the asymmetric tube waveshaper
// Fixed-point constants of the tube curve in Q.30 and the curve region type.
// ----------------------------------------------------------------------------
package atw_pkg;

	localparam int XW = 36;
	localparam int YW = 34;
	localparam int MW = 30;
	localparam int LW = 29;
	localparam int CURVE_STAGES = 6;

	localparam logic [15:0] DRIVE_RESET = 16'd4096;

	localparam logic signed [XW-1:0] ONE_X      = 36'sd1073741824;
	localparam logic signed [XW-1:0] HI_KNEE_X  = 36'sd343616711;
	localparam logic signed [XW-1:0] MID_KNEE_X = 36'sd95616709;
	localparam logic signed [XW-1:0] OFFS_X     = 36'sd31138513;

	localparam logic signed [YW-1:0] ONE_Y       = 34'sd1073741824;
	localparam logic signed [YW-1:0] HI_LEVEL_Y  = 34'sd676494930;
	localparam logic signed [YW-1:0] LOW_LEVEL_Y = 34'sd1054199723;
	localparam logic signed [YW-1:0] BIAS_Y      = 34'sd10737418;

	localparam logic [32:0]   QUAD_A = 33'd6606733443;
	localparam logic [LW-1:0] LIN_A  = 29'd357556027;

	typedef enum logic [3:0] {
		RGN_HI   = 4'b0001,
		RGN_QUAD = 4'b0010,
		RGN_LOW  = 4'b0100,
		RGN_NEG  = 4'b1000
	} region_t;

endpackage

// ===== rtl/core/atw_curve.sv =====
// ----------------------------------------------------------------------------
// atw_curve: tube curve pipeline
// Six register stages from the driven sample x (Q.30) to the curve value y.
// ----------------------------------------------------------------------------
module atw_curve (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [atw_pkg::XW-1:0]  x,
	output logic signed [atw_pkg::YW-1:0]  y
);
	import atw_pkg::*;

	region_t                 rgn_c;
	logic signed [XW-1:0]    a_w;
	logic signed [XW-1:0]    b_w;
	logic signed [XW-1:0]    abs_w;
	logic [MW-1:0]           m_c;

	region_t                 rgn_s2, rgn_s3, rgn_s4, rgn_s5, rgn_s6;
	logic [MW-1:0]           m_s2, a_s2;
	logic signed [31:0]      xq_s2, xq_s3, xq_s4, xq_s5, xq_s6;

	logic [2*MW-1:0]         sq_p;
	logic [LW+MW-1:0]        lin_p;
	logic [MW-1:0]           sq_s3;
	logic [LW-1:0]           lin_s3, lin_s4, lin_s5, lin_s6;

	logic [32:0]             op4;
	logic [MW+32:0]          p4;
	logic [MW-1:0]           r4_s4, r4_s5, r4_s6;

	logic [2*MW-1:0]         p5;
	logic [MW-1:0]           b8_s5;

	logic [2*MW-1:0]         p6;
	logic [MW-1:0]           b12_s6;

	logic signed [38:0]      x63;
	logic signed [YW-1:0]    inner;
	logic signed [YW-1:0]    tri3;
	logic signed [YW-1:0]    y_c;
	logic signed [YW-1:0]    y_s7;

	always_comb begin
		if (x >= HI_KNEE_X) begin
			rgn_c = RGN_HI;
		end else if (x >= -MID_KNEE_X) begin
			rgn_c = RGN_QUAD;
		end else if (x >= -ONE_X) begin
			rgn_c = RGN_LOW;
		end else begin
			rgn_c = RGN_NEG;
		end
		a_w   = -x - OFFS_X;
		b_w   = ONE_X - a_w;
		abs_w = x[XW-1] ? -x : x;
		m_c   = (rgn_c == RGN_QUAD) ? abs_w[MW-1:0] : b_w[MW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgn_s2 <= rgn_c;
			m_s2   <= m_c;
			a_s2   <= a_w[MW-1:0];
			xq_s2  <= x[31:0];
		end
	end

	always_comb begin
		sq_p  = m_s2 * m_s2;
		lin_p = LIN_A * a_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgn_s3 <= rgn_s2;
			xq_s3  <= xq_s2;
			sq_s3  <= sq_p[2*MW-1:MW];
			lin_s3 <= lin_p[LW+MW-1:MW];
		end
	end

	always_comb begin
		op4 = (rgn_s3 == RGN_QUAD) ? QUAD_A : {3'b000, sq_s3};
		p4  = op4 * sq_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgn_s4 <= rgn_s3;
			xq_s4  <= xq_s3;
			lin_s4 <= lin_s3;
			r4_s4  <= p4[2*MW-1:MW];
		end
	end

	assign p5 = r4_s4 * r4_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			rgn_s5 <= rgn_s4;
			xq_s5  <= xq_s4;
			lin_s5 <= lin_s4;
			r4_s5  <= r4_s4;
			b8_s5  <= p5[2*MW-1:MW];
		end
	end

	assign p6 = b8_s5 * r4_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			rgn_s6 <= rgn_s5;
			xq_s6  <= xq_s5;
			lin_s6 <= lin_s5;
			r4_s6  <= r4_s5;
			b12_s6 <= p6[2*MW-1:MW];
		end
	end

	always_comb begin
		x63   = (39'(xq_s6) <<< 6) - 39'(xq_s6);
		inner = ONE_Y - $signed({4'b0000, b12_s6}) + $signed({5'b00000, lin_s6});
		tri3  = (inner <<< 1) + inner;
		unique case (rgn_s6)
			RGN_HI:   y_c = HI_LEVEL_Y;
			RGN_QUAD: y_c = YW'(x63 >>> 4) - $signed({4'b0000, r4_s6});
			RGN_LOW:  y_c = BIAS_Y - (tri3 >>> 2);
			RGN_NEG:  y_c = -LOW_LEVEL_Y;
			default:  y_c = -LOW_LEVEL_Y;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s7 <= y_c;
		end
	end

	assign y = y_s7;

endmodule

// ===== rtl/core/asymmetric_tube_waveshaper.sv =====
// ----------------------------------------------------------------------------
// asymmetric_tube_waveshaper: drive gain and asymmetric tube distortion curve
// Streams signed audio samples through gain and a four-region tube curve.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one signed Q1.(SAMPLE_BITS-1) sample per item in the low
//   SAMPLE_BITS bits of tdata; m_axis returns one shaped Q2.(SAMPLE_BITS-2)
//   sample per item, saturated, in the same order.
//   drive_wr_en/drive_wr_data set the drive gain (unsigned Q4.12, gain/100);
//   write it only while no item is in flight.
//   Throughput is one item per cycle while the receiver does not stall. An
//   item passes nine register stages; the twelfth-power branch chains four
//   multiplications, each followed by a register.
//   The output register holds the finished item; while the receiver stalls
//   the whole pipeline holds and s_axis_tready drops, so nothing is lost or
//   repeated. Bubbles stay in place.
//   Reset clears all valid bits and loads drive with 1.0.
// ----------------------------------------------------------------------------
module asymmetric_tube_waveshaper #(
	parameter int SAMPLE_BITS = 24,
	localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  drive_wr_en,
	input  logic [15:0]           drive_wr_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [TDATA_BITS-1:0] s_axis_tdata,   // [SAMPLE_BITS-1:0] sample_in
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [TDATA_BITS-1:0] m_axis_tdata    // [SAMPLE_BITS-1:0] sample_out
);
	import atw_pkg::*;

	localparam int PW    = SAMPLE_BITS + 17;
	localparam int XSH   = SAMPLE_BITS - 19;
	localparam int RSH   = 32 - SAMPLE_BITS;
	localparam int NSTG  = CURVE_STAGES + 3;
	localparam int ZW    = 36;
	localparam logic signed [ZW-1:0] RND     = (36'sd1 <<< RSH) >>> 1;
	localparam logic signed [ZW-1:0] OUT_MAX = (36'sd1 <<< (SAMPLE_BITS - 1)) - 36'sd1;
	localparam logic signed [ZW-1:0] OUT_MIN = -(36'sd1 <<< (SAMPLE_BITS - 1));

	logic [15:0]                 drive_q;
	logic                        en;
	logic [NSTG:1]               vld_s;

	logic signed [SAMPLE_BITS-1:0] smp;
	logic signed [PW-1:0]        prod_c;
	logic signed [PW-1:0]        prod_s1;
	logic signed [XW-1:0]        x;
	logic signed [YW-1:0]        y;

	logic signed [ZW-1:0]        z_c;
	logic signed [ZW-1:0]        z_s8;
	logic signed [ZW-1:0]        zs;
	logic [SAMPLE_BITS-1:0]      sat_c;
	logic [SAMPLE_BITS-1:0]      smp_s9;

	assign en            = !vld_s[NSTG] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_s[NSTG];
	assign m_axis_tdata  = TDATA_BITS'(smp_s9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q <= DRIVE_RESET;
		end else if (drive_wr_en) begin
			drive_q <= drive_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NSTG-1:1], s_axis_tvalid};
		end
	end

	always_comb begin
		smp    = s_axis_tdata[SAMPLE_BITS-1:0];
		prod_c = smp * $signed({1'b0, drive_q});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_c;
		end
	end

	generate
		if (XSH >= 0) begin : g_shr
			assign x = XW'(prod_s1 >>> XSH);
		end else begin : g_shl
			assign x = XW'(prod_s1) <<< (-XSH);
		end
	endgenerate

	atw_curve u_curve (
		.clk (clk),
		.en  (en),
		.x   (x),
		.y   (y)
	);

	assign z_c = ZW'(y) + ZW'(y >>> 1) + RND;

	always_ff @(posedge clk) begin
		if (en) begin
			z_s8 <= z_c;
		end
	end

	always_comb begin
		zs = z_s8 >>> RSH;
		priority if (zs > OUT_MAX) begin
			sat_c = OUT_MAX[SAMPLE_BITS-1:0];
		end else if (zs < OUT_MIN) begin
			sat_c = OUT_MIN[SAMPLE_BITS-1:0];
		end else begin
			sat_c = zs[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smp_s9 <= sat_c;
		end
	end

endmodule

// ===== tb/sv/asymmetric_tube_waveshaper_test.sv =====
// ----------------------------------------------------------------------------
// asymmetric_tube_waveshaper_test: self-checking bench for the tube waveshaper
// Streams signed samples through the block under several drive settings and
// checks each shaped sample against a fixed-point curve model or typed value.
// The directed table covers the region knees, the full-scale corners, zero
// drive and full drive. Random traffic follows with bursty input and a
// stalling receiver that holds off once for a long stretch.
// ----------------------------------------------------------------------------
module asymmetric_tube_waveshaper_test;

	localparam int SAMPLE_BITS = 24;
	localparam int STUCK_LIMIT = 4000;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_ITEMS = 100;
	localparam int HOLD_CYCLES = 120;

	localparam longint Q_ONE       = 64'sd1073741824;
	localparam longint Q_HI_KNEE   = 64'sd343616711;
	localparam longint Q_HI_LEVEL  = 64'sd676494930;
	localparam longint Q_MID_KNEE  = 64'sd95616709;
	localparam longint Q_QUAD_A    = 64'sd6606733443;
	localparam longint Q_OFFS      = 64'sd31138513;
	localparam longint Q_LIN       = 64'sd357556027;
	localparam longint Q_LOW_LEVEL = 64'sd1054199723;
	localparam longint Q_BIAS      = 64'sd10737418;
	localparam longint OUT_MIN     = -64'sd8388608;
	localparam longint OUT_MAX     = 64'sd8388607;

	typedef struct {
		int drv;
		int smp;
		bit typed;
		int want;
	} shaper_row_t;

	logic        clk;
	logic        arst_n;
	logic        drive_wr_en;
	logic [15:0] drive_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // [23:0] sample_in
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // [23:0] sample_out

	logic signed [23:0] shaped_q[$];
	logic signed [23:0] shaped_want;
	logic [15:0]        drive_q;
	int                 burst_left;
	int                 samples_in;
	int                 samples_out;
	int                 mismatches;
	int                 drive_settings;
	int                 stuck_cycles;
	bit                 long_hold_done;

	shaper_row_t directed_rows[] = '{
		'{4096, 0, 1'b1, 0},
		'{4096, 1, 1'b0, 0},
		'{4096, -1, 1'b0, 0},
		'{4096, 8388607, 1'b1, 3963837},
		'{4096, -8388608, 1'b0, 0},
		'{4096, 2684505, 1'b0, 0},
		'{4096, 2684506, 1'b0, 0},
		'{4096, -747005, 1'b0, 0},
		'{4096, -747006, 1'b0, 0},
		'{4096, 4194304, 1'b0, 0},
		'{4096, -4194304, 1'b0, 0},
		'{4096, 1000000, 1'b0, 0},
		'{4096, -2000000, 1'b0, 0},
		'{0, 8388607, 1'b1, 0},
		'{0, -8388608, 1'b1, 0},
		'{0, 12345, 1'b1, 0},
		'{65535, 8388607, 1'b1, 3963837},
		'{65535, -8388608, 1'b1, -6176952},
		'{65535, -1, 1'b0, 0},
		'{65535, 1, 1'b0, 0},
		'{65535, 100, 1'b0, 0},
		'{65535, -30000, 1'b0, 0},
		'{65535, 600000, 1'b0, 0},
		'{65535, -600000, 1'b0, 0}
	};

	asymmetric_tube_waveshaper #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.drive_wr_en(drive_wr_en),
		.drive_wr_data(drive_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint q30_mul(input longint a, input longint b);
		return (a * b) >>> 30;
	endfunction

	function automatic logic signed [23:0] tube_shape(input logic signed [23:0] smp,
			input logic [15:0] drv);
		longint x, y, x2, a, b, b2, b4, b8, b12, inner;
		x = (longint'(smp) * longint'(drv)) >>> 5;
		if (x >= Q_HI_KNEE) begin
			y = Q_HI_LEVEL;
		end else if (x >= -Q_MID_KNEE) begin
			x2 = q30_mul(x, x);
			y = -q30_mul(Q_QUAD_A, x2) + ((63 * x) >>> 4);
		end else if (x >= -Q_ONE) begin
			a = -x - Q_OFFS;
			b = Q_ONE - a;
			b2 = q30_mul(b, b);
			b4 = q30_mul(b2, b2);
			b8 = q30_mul(b4, b4);
			b12 = q30_mul(b8, b4);
			inner = Q_ONE - b12 + q30_mul(Q_LIN, a);
			y = -((3 * inner) >>> 2) + Q_BIAS;
		end else begin
			y = -Q_LOW_LEVEL;
		end
		y = y + (y >>> 1);
		y = (y + 128) >>> 8;
		if (y < OUT_MIN)
			y = OUT_MIN;
		if (y > OUT_MAX)
			y = OUT_MAX;
		return y[23:0];
	endfunction

	task automatic report_mismatch(input string what, input logic signed [23:0] got,
			input logic signed [23:0] want);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
	endtask

	task automatic set_drive(input logic [15:0] v);
		s_axis_tvalid <= 1'b0;
		while (shaped_q.size() != 0)
			@(posedge clk);
		drive_wr_en <= 1'b1;
		drive_wr_data <= v;
		@(posedge clk);
		drive_wr_en <= 1'b0;
		drive_q = v;
		drive_settings++;
	endtask

	task automatic offer_sample(input logic signed [23:0] smp, input bit typed,
			input logic signed [23:0] want);
		int gap;
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= smp;
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
		shaped_q.push_back(typed ? want : tube_shape(smp, drive_q));
		samples_in++;
	endtask

	function automatic logic signed [23:0] random_sample();
		logic signed [23:0] smp;
		logic [31:0] r;
		r = $urandom;
		smp = r[23:0];
		case ($urandom_range(0, 4))
			0: ;
			1, 2, 3: smp = smp >>> $urandom_range(0, 23);
			default: begin
				case ($urandom_range(0, 4))
					0: smp = 24'sh7FFFFF;
					1: smp = 24'sh800000;
					2: smp = 24'sh000000;
					3: smp = 24'shFFFFFF;
					default: smp = 24'sh000001;
				endcase
			end
		endcase
		return smp;
	endfunction

	function automatic logic [15:0] random_drive();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'($urandom_range(0, 8191));
			2: return 16'($urandom_range(3500, 4700));
			default: return 16'($urandom_range(1, 512));
		endcase
	endfunction

	// hold off once for a long stretch so the pipeline fills and stalls input
	initial begin
		int seg_len, stall_pct, hold_cnt;
		m_axis_tready = 1'b0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			seg_len = $urandom_range(5, 60);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 80;
			endcase
			repeat (seg_len) begin
				@(posedge clk);
				m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
			if (!long_hold_done && samples_out >= 150) begin
				long_hold_done = 1'b1;
				@(posedge clk);
				m_axis_tready <= 1'b0;
				for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
					@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (shaped_q.size() == 0) begin
				report_mismatch("sample_out with nothing pending", m_axis_tdata, 24'sd0);
			end else begin
				shaped_want = shaped_q.pop_front();
				if (m_axis_tdata !== shaped_want)
					report_mismatch("sample_out", m_axis_tdata, shaped_want);
			end
			samples_out++;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("no item moved for %0d cycles", STUCK_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int ph, k;
		clk = 1'b0;
		arst_n = 1'b0;
		drive_wr_en = 1'b0;
		drive_wr_data = 16'd0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 24'd0;
		drive_q = 16'd4096;
		burst_left = 0;
		samples_in = 0;
		samples_out = 0;
		mismatches = 0;
		drive_settings = 1;
		stuck_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (16'(directed_rows[i].drv) != drive_q)
				set_drive(16'(directed_rows[i].drv));
			offer_sample(24'(directed_rows[i].smp), directed_rows[i].typed,
				24'(directed_rows[i].want));
		end

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_drive(random_drive());
			for (k = 0; k < PHASE_ITEMS; k++)
				offer_sample(random_sample(), 1'b0, 24'sd0);
		end

		s_axis_tvalid <= 1'b0;
		while (shaped_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("shaped %0d samples under %0d drive settings, zero and full drive included",
			samples_in, drive_settings);
		$display("received %0d results, with one long receiver hold-off", samples_out);
		if (mismatches == 0 && shaped_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
